[rtl/ils_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ils_pkg: shared types and constants of the integer literal scanner
// Character codes, operation codes between front and back, status codes.
// ============================================================================
package ils_pkg;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SUFFIX = 8'h6e;  // 'n'
    localparam logic [7:0] RESET_RADIX = 8'd10;

    localparam int IN_DATA_W  = 24;   // 8 + 8 + 1 bits, padded to bytes
    localparam int OUT_DATA_W = 72;   // 3 + 64 bits, padded to bytes

    // What the back end does with one classified character
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,   // accepted suffix character
        OP_DIGIT = 2'd1,   // shift-add a digit into the accumulator
        OP_CLEAR = 2'd2,   // prefix matching the radix: restart value
        OP_BAD   = 2'd3    // syntax error
    } op_t;

    // Radix of a digit operation, selects the shift-add form
    typedef enum logic [1:0] {
        RX_2  = 2'd0,
        RX_8  = 2'd1,
        RX_10 = 2'd2,
        RX_16 = 2'd3
    } radix_sel_t;

    typedef enum logic [2:0] {
        ST_I32       = 3'd0,
        ST_I64       = 3'd1,
        ST_U64       = 3'd2,
        ST_RANGE     = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    // One item handed from front to back
    typedef struct packed {
        op_t        op;
        radix_sel_t rsel;
        logic [3:0] digit;
        logic       last;
    } entry_t;

endpackage

[rtl/ils_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// ils_front: character classifier
// Tracks position, radix and suffix flag of the literal and turns each
// character into one back-end operation.
// ============================================================================
module ils_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,          // item accepted this cycle
    input  logic [7:0]          char_code,
    input  logic [7:0]          radix,
    input  logic                suffix_required,
    input  logic                last_char,
    output ils_pkg::entry_t     entry
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] held_radix_reg;
    logic       held_suffix_reg;
    logic       lead_zero_reg;

    logic       first;
    logic [7:0] radix_eff;
    logic       suffix_eff;
    logic       radix_good;
    logic       dig_valid;
    logic [3:0] dig_val;
    logic       is_prefix;
    logic [7:0] prefix_rx;
    ils_pkg::radix_sel_t rsel;

    assign first      = (pos_reg == 2'd0);
    assign radix_eff  = first ? radix : held_radix_reg;
    assign suffix_eff = first ? suffix_required : held_suffix_reg;

    always_comb
    begin
        radix_good = 1'b1;
        rsel       = ils_pkg::RX_10;
        case (radix_eff)
            8'd2:    rsel = ils_pkg::RX_2;
            8'd8:    rsel = ils_pkg::RX_8;
            8'd10:   rsel = ils_pkg::RX_10;
            8'd16:   rsel = ils_pkg::RX_16;
            default: radix_good = 1'b0;
        endcase
    end

    always_comb
    begin
        dig_valid = 1'b1;
        dig_val   = 4'd0;
        case (char_code) inside
            [8'h30:8'h39]: dig_val = 4'(char_code - 8'h30);
            [8'h61:8'h66]: dig_val = 4'(char_code - 8'h61 + 8'd10);
            [8'h41:8'h46]: dig_val = 4'(char_code - 8'h41 + 8'd10);
            default:       dig_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        is_prefix = 1'b1;
        prefix_rx = 8'd0;
        case (char_code) inside
            8'h62, 8'h42: prefix_rx = 8'd2;
            8'h6f, 8'h4f: prefix_rx = 8'd8;
            8'h78, 8'h58: prefix_rx = 8'd16;
            default:      is_prefix = 1'b0;
        endcase
    end

    always_comb
    begin
        entry.rsel  = rsel;
        entry.digit = dig_val;
        entry.last  = last_char;
        if (last_char && suffix_eff)
        begin
            entry.op = (char_code == ils_pkg::CHAR_SUFFIX) ? ils_pkg::OP_NOP
                                                           : ils_pkg::OP_BAD;
        end
        else if (pos_reg == 2'd1 && lead_zero_reg && is_prefix)
        begin
            entry.op = (prefix_rx == held_radix_reg) ? ils_pkg::OP_CLEAR
                                                     : ils_pkg::OP_BAD;
        end
        else if (!dig_valid || !radix_good || ({4'd0, dig_val} >= radix_eff))
        begin
            entry.op = ils_pkg::OP_BAD;
        end
        else
        begin
            entry.op = ils_pkg::OP_DIGIT;
        end
    end

    always_comb
    begin
        if (last_char)
            pos_next = 2'd0;
        else if (pos_reg == 2'd2)
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 2'd0;
            held_radix_reg  <= ils_pkg::RESET_RADIX;
            held_suffix_reg <= 1'b0;
            lead_zero_reg   <= 1'b0;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            if (first)
            begin
                held_radix_reg  <= radix;
                held_suffix_reg <= suffix_required;
                lead_zero_reg   <= (char_code == ils_pkg::CHAR_ZERO);
            end
        end
    end

endmodule

[rtl/ils_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// ils_queue: two-entry queue between classifier and accumulator
// Lets the front keep taking characters while the back waits on output.
// ============================================================================
module ils_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ils_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output ils_pkg::entry_t head
);

    ils_pkg::entry_t slots_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/ils_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// ils_back: value accumulator and result register
// Shift-add of one queued digit per cycle, sticky overflow, status on last item
// ============================================================================
module ils_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,        // queue holds an entry
    input  ils_pkg::entry_t head,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [2:0]      status,
    output logic [63:0]     magnitude
);

    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        bad_reg, bad_next;
    logic        seen_reg, seen_next;
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [63:0] mag_reg;

    logic [67:0] wide;
    logic [67:0] prod;
    logic        room;
    ils_pkg::status_t st;

    assign wide = {4'd0, acc_reg};

    always_comb
    begin
        case (head.rsel)
            ils_pkg::RX_2:  prod = (wide << 1) + {64'd0, head.digit};
            ils_pkg::RX_8:  prod = (wide << 3) + {64'd0, head.digit};
            ils_pkg::RX_10: prod = (wide << 3) + (wide << 1) + {64'd0, head.digit};
            ils_pkg::RX_16: prod = (wide << 4) + {64'd0, head.digit};
            default:        prod = wide;
        endcase
    end

    // A last entry needs the result register free; others always proceed
    assign room = !out_valid_reg || res_ready;
    assign pop  = avail && (room || !head.last);

    always_comb
    begin
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;
        seen_next = seen_reg;
        case (head.op)
            ils_pkg::OP_DIGIT:
            begin
                acc_next  = prod[63:0];
                ovf_next  = ovf_reg | (|prod[67:64]);
                seen_next = 1'b1;
            end
            ils_pkg::OP_CLEAR:
            begin
                acc_next  = 64'd0;
                ovf_next  = 1'b0;
                seen_next = 1'b0;
            end
            ils_pkg::OP_BAD: bad_next = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        if (bad_next || !seen_next)
            st = ils_pkg::ST_MALFORMED;
        else if (ovf_next)
            st = ils_pkg::ST_RANGE;
        else if (acc_next[63:31] == 33'd0)
            st = ils_pkg::ST_I32;
        else if (!acc_next[63])
            st = ils_pkg::ST_I64;
        else
            st = ils_pkg::ST_U64;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            ovf_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                if (head.last)
                begin
                    acc_reg  <= 64'd0;
                    ovf_reg  <= 1'b0;
                    bad_reg  <= 1'b0;
                    seen_reg <= 1'b0;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    ovf_reg  <= ovf_next;
                    bad_reg  <= bad_next;
                    seen_reg <= seen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            status_reg <= st;
            mag_reg    <= (st == ils_pkg::ST_MALFORMED || st == ils_pkg::ST_RANGE)
                          ? 64'd0 : acc_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign status    = status_reg;
    assign magnitude = mag_reg;

endmodule

[rtl/integer_literal_scanner.sv]
`timescale 1ns / 1ps
// ============================================================================
// integer_literal_scanner: streaming parser for radix integer literals
// Checks syntax, accumulates the value and classifies its range.
// ============================================================================
// Feed one character per item on the slave side; the first item of a
// literal latches radix (2, 8, 10 or 16) and suffix_required, and tlast
// marks the final character. An optional 0b/0o/0x prefix (either case)
// after a leading zero must name the latched radix, and a closing 'n' is
// required exactly when suffix_required was set. One result item comes out
// per literal, on the master side, with status (0 fits i32, 1 fits i64,
// 2 fits u64, 3 out of range, 4 malformed) and the value, which reads zero
// for out of range or malformed. The block takes one character every
// cycle while the queue is not full: the classifier, a two-entry queue
// and a single shift-add accumulator each handle one item per clock, and
// a result passes the queue before it reaches the output register. A
// stalled result only holds back the last character of the next literal;
// the characters before it keep flowing into the accumulator.
// ============================================================================
module integer_literal_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    // character input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] char_code, [15:8] radix, [16] suffix_required, rest zero
    input  logic [ils_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,     // last_char
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [66:3] magnitude, rest zero
    output logic [ils_pkg::OUT_DATA_W-1:0] m_tdata
);

    ils_pkg::entry_t front_entry;
    ils_pkg::entry_t head;
    logic            q_full;
    logic            q_nonempty;
    logic            take;
    logic            pop;
    logic [2:0]      status;
    logic [63:0]     magnitude;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    // Classify the character against the latched literal context
    ils_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .char_code       (s_tdata[7:0]),
        .radix           (s_tdata[15:8]),
        .suffix_required (s_tdata[16]),
        .last_char       (s_tlast),
        .entry           (front_entry)
    );

    ils_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .nonempty   (q_nonempty),
        .head       (head)
    );

    // Accumulate and report
    ils_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (q_nonempty),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .status    (status),
        .magnitude (magnitude)
    );

    assign m_tdata = {5'd0, magnitude, status};

endmodule
